// ===== hdl/quaternion_rotate_vector_top_defines.svh =====
// Assertion macros for the quaternion vector rotation block.
`ifndef QUATERNION_ROTATE_VECTOR_TOP_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QRV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrv assertion failed");

// Next-cycle implication, disabled during reset.
`define QRV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrv assertion failed");

`endif

// ===== hdl/qrv_pkg.sv =====
// Shared constants and types for the quaternion vector rotation block.
`default_nettype none
package qrv_pkg;

   localparam int QUAT_FRAC_BITS = 14;
   localparam int QUAT_W         = 16;
   localparam int VEC_W          = 24;

   // quaternion products, then the 2*(a +/- b) matrix terms
   localparam int QPROD_W = 2 * QUAT_W;
   localparam int M_W     = QPROD_W + 2;
   // matrix term times vector component, and the sum of three of them
   localparam int PROD_W  = M_W + VEC_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int SHIFT   = 2 * QUAT_FRAC_BITS;
   localparam int RND_W   = SUM_W - SHIFT;

   localparam int NUM_LANES = 3;

   // pipeline stages
   localparam int NUM_STAGES = 5;
   localparam int STG_PROD   = 0;
   localparam int STG_COEF   = 1;
   localparam int STG_MUL    = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_OUT    = 4;

   localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
   localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

   typedef logic signed [QUAT_W-1:0] quat_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [M_W-1:0]    coef_type;

   typedef vec_type  [NUM_LANES-1:0] vec3_type;
   typedef coef_type [NUM_LANES-1:0] coef_row_type;
   typedef coef_row_type [NUM_LANES-1:0] coef_mat_type;

   // per-stage load enables
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/qrv_coef.sv =====
// Quaternion products and rotation matrix terms, two pipeline stages.
`default_nettype none
module qrv_coef
   import qrv_pkg::*;
(
   input  wire logic          clock,
   input  wire pipe_ctrl_type ctrl,
   input  wire quat_type      quat_w,
   input  wire quat_type      quat_x,
   input  wire quat_type      quat_y,
   input  wire quat_type      quat_z,
   input  wire vec3_type      vec,
   output coef_mat_type       mat,
   output vec3_type           vec_out
);

   logic signed [QPROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [QPROD_W-1:0] wx_ff, wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QPROD_W-1:0] ww_in, xx_in, yy_in, zz_in;
   logic signed [QPROD_W-1:0] wx_in, wy_in, wz_in, xy_in, xz_in, yz_in;
   vec3_type                  vec_s1_ff;
   vec3_type                  vec_s2_ff;
   coef_mat_type              mat_ff;
   coef_mat_type              mat_in;

   always_comb begin
      ww_in = quat_w * quat_w;
      xx_in = quat_x * quat_x;
      yy_in = quat_y * quat_y;
      zz_in = quat_z * quat_z;
      wx_in = quat_w * quat_x;
      wy_in = quat_w * quat_y;
      wz_in = quat_w * quat_z;
      xy_in = quat_x * quat_y;
      xz_in = quat_x * quat_z;
      yz_in = quat_y * quat_z;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_PROD]) begin
         ww_ff     <= ww_in;
         xx_ff     <= xx_in;
         yy_ff     <= yy_in;
         zz_ff     <= zz_in;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
         wz_ff     <= wz_in;
         xy_ff     <= xy_in;
         xz_ff     <= xz_in;
         yz_ff     <= yz_in;
         vec_s1_ff <= vec;
      end
   end

   always_comb begin
      mat_in[0][0] = M_W'(ww_ff) + M_W'(xx_ff) - M_W'(yy_ff) - M_W'(zz_ff);
      mat_in[0][1] = (M_W'(xy_ff) - M_W'(wz_ff)) <<< 1;
      mat_in[0][2] = (M_W'(xz_ff) + M_W'(wy_ff)) <<< 1;
      mat_in[1][0] = (M_W'(xy_ff) + M_W'(wz_ff)) <<< 1;
      mat_in[1][1] = M_W'(ww_ff) - M_W'(xx_ff) + M_W'(yy_ff) - M_W'(zz_ff);
      mat_in[1][2] = (M_W'(yz_ff) - M_W'(wx_ff)) <<< 1;
      mat_in[2][0] = (M_W'(xz_ff) - M_W'(wy_ff)) <<< 1;
      mat_in[2][1] = (M_W'(yz_ff) + M_W'(wx_ff)) <<< 1;
      mat_in[2][2] = M_W'(ww_ff) - M_W'(xx_ff) - M_W'(yy_ff) + M_W'(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_COEF]) begin
         mat_ff    <= mat_in;
         vec_s2_ff <= vec_s1_ff;
      end
   end

   assign mat     = mat_ff;
   assign vec_out = vec_s2_ff;

endmodule
`default_nettype wire

// ===== hdl/qrv_lane.sv =====
// One output row: three products, row sum, round and saturate.
`default_nettype none
module qrv_lane
   import qrv_pkg::*;
(
   input  wire logic          clock,
   input  wire pipe_ctrl_type ctrl,
   input  wire coef_row_type  coef_row,
   input  wire vec3_type      vec,
   output vec_type            result,
   output logic               sat
);

   logic signed [PROD_W-1:0] prod_ff [NUM_LANES];
   logic signed [PROD_W-1:0] prod_in [NUM_LANES];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  rnd;
   logic signed [RND_W-1:0]  quo;
   coef_type                 coef_j;
   vec_type                  vec_j;

   always_comb begin
      for (int j = 0; j < NUM_LANES; j++) begin
         coef_j     = coef_row[j];
         vec_j      = vec[j];
         prod_in[j] = coef_j * vec_j;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_MUL]) begin
         for (int j = 0; j < NUM_LANES; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
   end

   assign sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   // round half up, drop the fraction, clip to the vector range
   always_comb begin
      rnd = sum_ff + (SUM_W'(1) <<< (SHIFT - 1));
      quo = rnd[SUM_W-1:SHIFT];
      priority if (quo > RND_W'(VEC_MAX)) begin
         result = VEC_MAX;
         sat    = 1'b1;
      end else if (quo < RND_W'(VEC_MIN)) begin
         result = VEC_MIN;
         sat    = 1'b1;
      end else begin
         result = quo[VEC_W-1:0];
         sat    = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/quaternion_rotate_vector_top.sv =====
// Registered stages in order: products, matrix terms, lane products, row sum, output.
// Throughput: one request per cycle; stages are elastic, so a request is
// still taken while a finished result waits, until every stage holds one.
// Path: quaternion products, matrix terms, three row lanes of 34x24
// multiplies, row sum, then round/saturate and merge into the output register.
// Reset clears the stage valid flags only; data registers are not reset.
`default_nettype none
`include "quaternion_rotate_vector_top_defines.svh"
module quaternion_rotate_vector_top
   import qrv_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire quat_type req_quat_w,
   input  wire quat_type req_quat_x,
   input  wire quat_type req_quat_y,
   input  wire quat_type req_quat_z,
   input  wire vec_type  req_vec_x,
   input  wire vec_type  req_vec_y,
   input  wire vec_type  req_vec_z,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output vec_type   rsp_out_north,
   output vec_type   rsp_out_east,
   output vec_type   rsp_out_up,
   output logic      rsp_saturated
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   pipe_ctrl_type         ctrl;
   vec3_type              vec_req;
   vec3_type              vec_s2;
   coef_mat_type          mat;
   vec_type               lane_res [NUM_LANES];
   logic [NUM_LANES-1:0]  lane_sat;
   vec_type               north_ff, east_ff, up_ff;
   logic                  sat_ff;
   logic                  req_only;
   logic                  out_at_limit;
   int                    fill_now;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      ctrl.adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctrl.adv[k] = !valid_ff[k] || ctrl.adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ctrl.adv[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ctrl.adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ctrl.adv[STG_PROD];

   assign vec_req[0] = req_vec_x;
   assign vec_req[1] = req_vec_y;
   assign vec_req[2] = req_vec_z;

   qrv_coef u_coef (
      .clock   (clock),
      .ctrl    (ctrl),
      .quat_w  (req_quat_w),
      .quat_x  (req_quat_x),
      .quat_y  (req_quat_y),
      .quat_z  (req_quat_z),
      .vec     (vec_req),
      .mat     (mat),
      .vec_out (vec_s2)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      qrv_lane u_lane (
         .clock    (clock),
         .ctrl     (ctrl),
         .coef_row (mat[i]),
         .vec      (vec_s2),
         .result   (lane_res[i]),
         .sat      (lane_sat[i])
      );
   end

   // merge the lanes into the output register
   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_OUT]) begin
         north_ff <= lane_res[0];
         east_ff  <= lane_res[1];
         up_ff    <= lane_res[2];
         sat_ff   <= |lane_sat;
      end
   end

   assign rsp_valid     = valid_ff[STG_OUT];
   assign rsp_out_north = north_ff;
   assign rsp_out_east  = east_ff;
   assign rsp_out_up    = up_ff;
   assign rsp_saturated = sat_ff;

   // a request enters while no result leaves
   assign req_only     = req_valid && !req_stall && !(rsp_valid && !rsp_stall);
   assign fill_now     = $countones(valid_ff);
   assign out_at_limit = rsp_out_north == VEC_MAX || rsp_out_north == VEC_MIN ||
                         rsp_out_east == VEC_MAX || rsp_out_east == VEC_MIN ||
                         rsp_out_up == VEC_MAX || rsp_out_up == VEC_MIN;

   `QRV_ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall, (&valid_ff))
   `QRV_ASSERT_NEXT(a_count_grows, clock, reset, req_only, (fill_now == $past(fill_now) + 1))
   `QRV_ASSERT_IMPLY(a_sat_at_limit, clock, reset, (rsp_valid && rsp_saturated), out_at_limit)

endmodule
`default_nettype wire
